>>> design/d2q9eq_pkg.sv
`timescale 1ns / 1ps

package d2q9eq_pkg;

   localparam int NUM_DIRECTIONS = 9;
   localparam int FRACTION_BITS  = 14;

   // port widths
   localparam int DENS_W      = 16;
   localparam int VEL_W       = 16;
   localparam int OUT_W       = 18;
   localparam int CSR_W       = 18;
   localparam int CSR_INDEX_W = 2;
   localparam int COMP_W      = 2;
   localparam int WSHIFT_W    = 3;

   localparam int NUM_STAGES = 7;

   // internal widths
   localparam int S_W   = VEL_W + 3;
   localparam int SQ_W  = 2 * S_W - 3;
   localparam int USQ_W = 2 * VEL_W;
   localparam int P_A   = SQ_W + 5;
   localparam int P_B   = 2 * FRACTION_BITS + 3;
   localparam int P_C   = S_W + FRACTION_BITS + 4;
   localparam int P_AB  = (P_A > P_B) ? P_A : P_B;
   localparam int P_W   = (P_AB > P_C) ? P_AB : P_C;
   localparam int T_W   = P_W - FRACTION_BITS - 1;
   localparam int PROD_W = DENS_W + 1 + T_W;
   localparam int Y_W   = PROD_W + 5;
   localparam int Z_W   = Y_W - FRACTION_BITS - 2;
   localparam int ZP_W  = OUT_W + 4;
   localparam int R_W   = ZP_W + 1;

   // division by nine through a reciprocal, one correction step after
   localparam int WEIGHT_DIV  = 9;
   localparam int RECIP_SHIFT = ZP_W + 4;
   localparam int RECIP_W     = RECIP_SHIFT - 3;
   localparam int Q_W         = ZP_W + RECIP_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / WEIGHT_DIV);

   // saturation window before the divide
   localparam int ZLIM = WEIGHT_DIV * (2 ** (OUT_W - 1));
   localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(ZLIM - 1);
   localparam logic signed [Z_W-1:0] Z_MIN = Z_W'(-ZLIM);
   localparam logic signed [Z_W-1:0] Z_OFS = Z_W'(ZLIM);
   localparam logic [OUT_W-1:0] OUT_OFS = OUT_W'(2 ** (OUT_W - 1));

   // bracket constant 2^(2F+1) plus the half-ulp for rounding T
   localparam logic signed [P_W-1:0] P_BIAS =
      (P_W'(1) <<< (2 * FRACTION_BITS + 1)) + (P_W'(1) <<< FRACTION_BITS);
   localparam logic signed [Y_W-1:0] Y_ROUND = Y_W'(18) <<< FRACTION_BITS;

   // weight numerators 16, 4, 1 as shifts
   localparam logic [WSHIFT_W-1:0] WEIGHT_SHIFT [NUM_DIRECTIONS] = '{
      3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0
   };

   localparam logic [CSR_W-1:0] DIR_X_RESET = 18'd128196;
   localparam logic [CSR_W-1:0] DIR_Y_RESET = 18'd251664;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIR_X = 2'd0,
      CSR_DIR_Y = 2'd1
   } csr_index_type;

   localparam logic [COMP_W-1:0] COMP_ZERO   = 2'b00;
   localparam logic [COMP_W-1:0] COMP_PLUS   = 2'b01;
   localparam logic [COMP_W-1:0] COMP_MINUS2 = 2'b10;
   localparam logic [COMP_W-1:0] COMP_MINUS  = 2'b11;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage

>>> design/d2q9eq_if.sv
`timescale 1ns / 1ps

interface d2q9eq_req_if import d2q9eq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [DENS_W-1:0]       density;
   logic signed [VEL_W-1:0] vel_x;
   logic signed [VEL_W-1:0] vel_y;
   logic                    last_cell;

   modport source (output valid, density, vel_x, vel_y, last_cell, input ready);
   modport sink (input valid, density, vel_x, vel_y, last_cell, output ready);
endinterface

interface d2q9eq_rsp_if import d2q9eq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] feq_0;
   logic signed [OUT_W-1:0] feq_1;
   logic signed [OUT_W-1:0] feq_2;
   logic signed [OUT_W-1:0] feq_3;
   logic signed [OUT_W-1:0] feq_4;
   logic signed [OUT_W-1:0] feq_5;
   logic signed [OUT_W-1:0] feq_6;
   logic signed [OUT_W-1:0] feq_7;
   logic signed [OUT_W-1:0] feq_8;
   logic                    last_cell_out;

   modport source (output valid, feq_0, feq_1, feq_2, feq_3, feq_4, feq_5, feq_6,
                   feq_7, feq_8, last_cell_out, input ready);
   modport sink (input valid, feq_0, feq_1, feq_2, feq_3, feq_4, feq_5, feq_6,
                 feq_7, feq_8, last_cell_out, output ready);
endinterface

>>> design/d2q9_equilibrium_distribution.sv
`timescale 1ns / 1ps
// throughput: one word per cycle; every pipeline stage holds one word and moves on
// when the stage after it is free, so the rate is set by the response side alone
// reset (synchronous, active high) empties the pipeline and loads the default
// D2Q9 direction set into both direction registers

module d2q9_equilibrium_distribution import d2q9eq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   d2q9eq_req_if.sink             req_port,
   d2q9eq_rsp_if.source           rsp_port,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   logic [CSR_W-1:0] dir_x_ff, dir_x_in;
   logic [CSR_W-1:0] dir_y_ff, dir_y_in;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] stage_load;
   logic [NUM_STAGES-1:0] last_ff, last_in;
   pipe_ctl_type          ctl;

   logic [DENS_W-1:0]       rho0_ff, rho1_ff, rho2_ff;
   logic [USQ_W-1:0]        usq0_ff, usq0_in;
   logic signed [P_W-1:0]   base1_ff, base1_in;
   logic signed [P_W-1:0]   usq_w;
   logic signed [2*VEL_W-1:0] sqx, sqy;

   logic signed [OUT_W-1:0] feq_w [NUM_DIRECTIONS];

   // direction registers
   always_comb begin
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIR_X: dir_x_in = csr_wdata;
            CSR_DIR_Y: dir_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_x_ff <= DIR_X_RESET;
         dir_y_ff <= DIR_Y_RESET;
      end else begin
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
      end
   end

   // a stage loads when empty or when the stage after it moves
   always_comb begin
      stage_load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_port.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_load[i] = !valid_ff[i] || stage_load[i+1];
      end
      valid_in = valid_ff;
      last_in  = last_ff;
      if (stage_load[0]) begin
         valid_in[0] = req_port.valid;
         last_in[0]  = req_port.last_cell;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (stage_load[i]) begin
            valid_in[i] = valid_ff[i-1];
            last_in[i]  = last_ff[i-1];
         end
      end
      ctl.load = stage_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // shared terms: |u|^2 and the bracket bias with -3|u|^2 folded in
   always_comb begin
      sqx      = req_port.vel_x * req_port.vel_x;
      sqy      = req_port.vel_y * req_port.vel_y;
      usq0_in  = unsigned'(sqx) + unsigned'(sqy);
      usq_w    = {{(P_W-USQ_W){1'b0}}, usq0_ff};
      base1_in = P_BIAS - (usq_w <<< 1) - usq_w;
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      if (stage_load[0]) begin
         rho0_ff <= req_port.density;
         usq0_ff <= usq0_in;
      end
      if (stage_load[1]) begin
         rho1_ff  <= rho0_ff;
         base1_ff <= base1_in;
      end
      if (stage_load[2]) begin
         rho2_ff <= rho1_ff;
      end
   end

   for (genvar k = 0; k < NUM_DIRECTIONS; k++) begin : g_lane
      d2q9eq_lane u_lane (
         .clock        (clock),
         .ctl          (ctl),
         .comp_x       (dir_x_ff[COMP_W*k +: COMP_W]),
         .comp_y       (dir_y_ff[COMP_W*k +: COMP_W]),
         .weight_shift (WEIGHT_SHIFT[k]),
         .vel_x        (req_port.vel_x),
         .vel_y        (req_port.vel_y),
         .bias         (base1_ff),
         .density      (rho2_ff),
         .feq          (feq_w[k])
      );
   end

   assign req_port.ready         = stage_load[0];
   assign rsp_port.valid         = valid_ff[NUM_STAGES-1];
   assign rsp_port.last_cell_out = last_ff[NUM_STAGES-1];
   assign rsp_port.feq_0         = feq_w[0];
   assign rsp_port.feq_1         = feq_w[1];
   assign rsp_port.feq_2         = feq_w[2];
   assign rsp_port.feq_3         = feq_w[3];
   assign rsp_port.feq_4         = feq_w[4];
   assign rsp_port.feq_5         = feq_w[5];
   assign rsp_port.feq_6         = feq_w[6];
   assign rsp_port.feq_7         = feq_w[7];
   assign rsp_port.feq_8         = feq_w[8];

   // a full pipeline with a stalled response must refuse new words
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_port.ready) |-> !req_port.ready)
      else $error("request taken while pipeline full and stalled");

   // backpressure only when every stage holds a word
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> &valid_ff)
      else $error("request refused with an empty stage");

   // a word leaving the second to last stage reaches the output register
   a_no_word_lost: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NUM_STAGES-2] && stage_load[NUM_STAGES-1]) |=> valid_ff[NUM_STAGES-1])
      else $error("word dropped before the output register");

endmodule

>>> design/d2q9eq_lane.sv
`timescale 1ns / 1ps

module d2q9eq_lane import d2q9eq_pkg::*; (
   input  logic                    clock,
   input  pipe_ctl_type            ctl,
   input  logic [COMP_W-1:0]       comp_x,
   input  logic [COMP_W-1:0]       comp_y,
   input  logic [WSHIFT_W-1:0]     weight_shift,
   input  logic signed [VEL_W-1:0] vel_x,
   input  logic signed [VEL_W-1:0] vel_y,
   input  logic signed [P_W-1:0]   bias,
   input  logic [DENS_W-1:0]       density,
   output logic signed [OUT_W-1:0] feq
);

   function automatic logic signed [S_W-1:0] scale_comp(
      input logic [COMP_W-1:0] c,
      input logic signed [VEL_W-1:0] v
   );
      logic signed [S_W-1:0] ve;
      ve = S_W'(v);
      case (c)
         COMP_ZERO:   scale_comp = '0;
         COMP_PLUS:   scale_comp = ve;
         COMP_MINUS2: scale_comp = -(ve <<< 1);
         COMP_MINUS:  scale_comp = -ve;
         default:     scale_comp = '0;
      endcase
   endfunction

   logic signed [S_W-1:0]     s0_ff, s0_in;
   logic signed [S_W-1:0]     s1_ff, s1_in;
   logic [SQ_W-1:0]           sq1_ff, sq1_in;
   logic signed [T_W-1:0]     t2_ff, t2_in;
   logic signed [PROD_W-1:0]  prod3_ff, prod3_in;
   logic [ZP_W-1:0]           zp4_ff, zp4_in;
   logic [ZP_W-1:0]           zp5_ff, zp5_in;
   logic [Q_W-1:0]            q5_ff, q5_in;
   logic signed [OUT_W-1:0]   feq6_ff, feq6_in;

   logic signed [2*S_W-1:0]           sq_full;
   logic signed [P_W-1:0]             s_w, sq_w, p_sum;
   logic signed [DENS_W:0]            rho_s;
   logic signed [Y_W-1:0]             y_sum;
   logic signed [Z_W-1:0]             z_raw, z_sat, z_ofs;
   logic [ZP_W+RECIP_W-1:0]           mul_full;
   logic [R_W-1:0]                    q9, rem;
   logic [Q_W-1:0]                    q_fix;
   logic [OUT_W-1:0]                  q_rebased;

   always_comb begin
      // stage 0: projection of the velocity on the direction
      s0_in = scale_comp(comp_x, vel_x) + scale_comp(comp_y, vel_y);

      // stage 1: square of the projection
      sq_full = s0_ff * s0_ff;
      sq1_in  = sq_full[SQ_W-1:0];
      s1_in   = s0_ff;

      // stage 2: bracket scaled by 2^(2F+1), then back to Q.F rounded half up
      s_w   = P_W'(s1_ff);
      sq_w  = {{(P_W-SQ_W){1'b0}}, sq1_ff};
      p_sum = bias + (s_w <<< (FRACTION_BITS + 2)) + (s_w <<< (FRACTION_BITS + 1))
              + (sq_w <<< 3) + sq_w;
      t2_in = p_sum[P_W-1 -: T_W];

      // stage 3: density times bracket
      rho_s    = {1'b0, density};
      prod3_in = rho_s * t2_ff;

      // stage 4: weight, round, drop 2^(F+2), clamp to the output window times nine
      y_sum = (Y_W'(prod3_ff) <<< weight_shift) + Y_ROUND;
      z_raw = y_sum[Y_W-1 -: Z_W];
      if (z_raw > Z_MAX) begin
         z_sat = Z_MAX;
      end else if (z_raw < Z_MIN) begin
         z_sat = Z_MIN;
      end else begin
         z_sat = z_raw;
      end
      z_ofs  = z_sat + Z_OFS;
      zp4_in = z_ofs[ZP_W-1:0];

      // stage 5: reciprocal multiply, quotient low by at most one
      mul_full = zp4_ff * RECIP;
      q5_in    = mul_full[RECIP_SHIFT +: Q_W];
      zp5_in   = zp4_ff;

      // stage 6: correction and rebase to signed
      q9    = (R_W'(q5_ff) <<< 3) + R_W'(q5_ff);
      rem   = R_W'(zp5_ff) - q9;
      q_fix = (rem >= R_W'(WEIGHT_DIV)) ? q5_ff + Q_W'(1) : q5_ff;
      q_rebased = q_fix[OUT_W-1:0] - OUT_OFS;
      feq6_in   = signed'(q_rebased);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s0_ff <= s0_in;
      end
      if (ctl.load[1]) begin
         s1_ff  <= s1_in;
         sq1_ff <= sq1_in;
      end
      if (ctl.load[2]) begin
         t2_ff <= t2_in;
      end
      if (ctl.load[3]) begin
         prod3_ff <= prod3_in;
      end
      if (ctl.load[4]) begin
         zp4_ff <= zp4_in;
      end
      if (ctl.load[5]) begin
         zp5_ff <= zp5_in;
         q5_ff  <= q5_in;
      end
      if (ctl.load[6]) begin
         feq6_ff <= feq6_in;
      end
   end

   assign feq = feq6_ff;

endmodule

>>> verif/tb_d2q9_equilibrium_distribution.sv
`timescale 1ns / 1ps

module tb_d2q9_equilibrium_distribution import d2q9eq_pkg::*; ();

   localparam int NUM_PHASES       = 6;
   localparam int CELLS_PER_PHASE  = 325;
   localparam int STALL_LIMIT      = 1000;
   localparam int LONG_HOLD        = 80;
   localparam longint OUT_MAX_VAL  = (longint'(1) <<< (OUT_W - 1)) - 1;
   localparam longint OUT_MIN_VAL  = -(longint'(1) <<< (OUT_W - 1));
   localparam longint WEIGHT_NUM [NUM_DIRECTIONS] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};

   // indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [CSR_W-1:0] DIR_ALL_MINUS  = 18'h3FFFF;
   localparam logic [CSR_W-1:0] DIR_ALL_MINUS2 = 18'h2AAAA;
   localparam logic [CSR_W-1:0] DIR_ALL_PLUS   = 18'h15555;
   localparam logic [CSR_W-1:0] DIR_ALL_ZERO   = 18'h00000;

   typedef struct packed {
      logic [0:NUM_DIRECTIONS-1][OUT_W-1:0] feq;
      logic                                 last_cell;
   } feq_word_type;

   typedef enum logic {ROW_CELL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  csr_index;
      logic [CSR_W-1:0]        csr_data;
      logic [DENS_W-1:0]       density;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic                    last_cell;
      logic                    has_typed;
      feq_word_type            typed_word;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_wdata;

   d2q9eq_req_if req_if ();
   d2q9eq_rsp_if rsp_if ();

   d2q9_equilibrium_distribution dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // travels with the offered word so the scoreboard knows a typed-in answer
   logic         offer_has_typed;
   feq_word_type offer_typed_word;
   bit           offer_burst;

   logic [CSR_W-1:0] dir_x_model;
   logic [CSR_W-1:0] dir_y_model;
   feq_word_type     feq_expected_q [$];
   int               mismatch_count;
   int               idle_cycles;

   stim_row_type     directed_rows [$];
   logic [CSR_W-1:0] phase_x [NUM_PHASES];
   logic [CSR_W-1:0] phase_y [NUM_PHASES];

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic feq_word_type equilibrium_word(
      input logic [DENS_W-1:0]       rho_in,
      input logic signed [VEL_W-1:0] ux_in,
      input logic signed [VEL_W-1:0] uy_in,
      input logic                    last_in,
      input logic [CSR_W-1:0]        x_set,
      input logic [CSR_W-1:0]        y_set
   );
      longint one_f, rho, ux, uy, usq, s, p, t, num, den, f;
      logic signed [COMP_W-1:0] cx, cy;
      feq_word_type w;
      one_f = longint'(1) <<< FRACTION_BITS;
      rho   = longint'(rho_in);
      ux    = longint'(ux_in);
      uy    = longint'(uy_in);
      usq   = ux * ux + uy * uy;
      den   = 36 * one_f;
      for (int k = 0; k < NUM_DIRECTIONS; k++) begin
         cx = x_set[2*k +: COMP_W];
         cy = y_set[2*k +: COMP_W];
         s  = cx * ux + cy * uy;
         p  = (longint'(1) <<< (2 * FRACTION_BITS + 1)) + 6 * s * one_f + 9 * s * s - 3 * usq;
         // bracket back to q.f, half up
         t   = (p + one_f) >>> (FRACTION_BITS + 1);
         num = WEIGHT_NUM[k] * rho * t + 18 * one_f;
         f   = num / den;
         if ((num % den) != 0 && num < 0) f = f - 1;
         if (f > OUT_MAX_VAL) f = OUT_MAX_VAL;
         else if (f < OUT_MIN_VAL) f = OUT_MIN_VAL;
         w.feq[k] = OUT_W'(f);
      end
      w.last_cell = last_in;
      return w;
   endfunction

   function automatic stim_row_type cell_row(input logic [DENS_W-1:0] d,
                                             input logic signed [VEL_W-1:0] vx,
                                             input logic signed [VEL_W-1:0] vy,
                                             input logic last);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_CELL;
      r.density   = d;
      r.vel_x     = vx;
      r.vel_y     = vy;
      r.last_cell = last;
      return r;
   endfunction

   // zero velocity or zero density: the answer depends on the weight class alone
   function automatic stim_row_type typed_row(input logic [DENS_W-1:0] d,
                                              input logic signed [VEL_W-1:0] vx,
                                              input logic signed [VEL_W-1:0] vy,
                                              input logic last,
                                              input int rest, input int axis, input int diag);
      stim_row_type r;
      r = cell_row(d, vx, vy, last);
      r.has_typed = 1'b1;
      r.typed_word.feq[0] = OUT_W'(rest);
      for (int k = 1; k < 5; k++) r.typed_word.feq[k] = OUT_W'(axis);
      for (int k = 5; k < NUM_DIRECTIONS; k++) r.typed_word.feq[k] = OUT_W'(diag);
      r.typed_word.last_cell = last;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_W-1:0] data);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_CSR;
      r.csr_index = idx;
      r.csr_data  = data;
      return r;
   endfunction

   function automatic logic signed [VEL_W-1:0] random_velocity();
      logic signed [VEL_W-1:0] v;
      case ($urandom_range(0, 9)) inside
         [0:5]: v = VEL_W'(int'($urandom_range(0, 8000)) - 4000);
         [6:7]: v = VEL_W'($urandom);
         8: begin
            case ($urandom_range(0, 3))
               0:       v = 16'sh8000;
               1:       v = 16'sh7FFF;
               2:       v = '0;
               default: v = '1;
            endcase
         end
         default: begin
            v = VEL_W'(1) << $urandom_range(0, VEL_W - 2);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic stim_row_type random_cell();
      logic [DENS_W-1:0] d;
      case ($urandom_range(0, 9)) inside
         [0:5]:   d = DENS_W'(10000 + $urandom_range(0, 20000));
         [6:7]:   d = DENS_W'($urandom);
         8:       d = $urandom_range(0, 1) ? '1 : '0;
         default: d = DENS_W'($urandom_range(0, 255));
      endcase
      return cell_row(d, random_velocity(), random_velocity(), $urandom_range(0, 31) == 0);
   endfunction

   function automatic int next_offer_gap();
      if ($urandom_range(0, 39) == 0) offer_burst = !offer_burst;
      return offer_burst ? 0 : $urandom_range(0, 5);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_cell(input stim_row_type r, input int gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.density   <= r.density;
      req_if.vel_x     <= r.vel_x;
      req_if.vel_y     <= r.vel_y;
      req_if.last_cell <= r.last_cell;
      offer_has_typed  <= r.has_typed;
      offer_typed_word <= r.typed_word;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // registers only change with nothing in flight
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (feq_expected_q.size() != 0);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : scoreboard
      feq_word_type got_w, exp_w;
      if (reset !== 1'b0) begin
         dir_x_model = DIR_X_RESET;
         dir_y_model = DIR_Y_RESET;
      end else begin
         if (req_if.valid && req_if.ready)
            feq_expected_q.push_back(offer_has_typed ? offer_typed_word :
               equilibrium_word(req_if.density, req_if.vel_x, req_if.vel_y,
                                req_if.last_cell, dir_x_model, dir_y_model));
         if (rsp_if.valid && rsp_if.ready) begin
            got_w.feq = {rsp_if.feq_0, rsp_if.feq_1, rsp_if.feq_2, rsp_if.feq_3, rsp_if.feq_4,
                         rsp_if.feq_5, rsp_if.feq_6, rsp_if.feq_7, rsp_if.feq_8};
            got_w.last_cell = rsp_if.last_cell_out;
            if (feq_expected_q.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               exp_w = feq_expected_q.pop_front();
               for (int k = 0; k < NUM_DIRECTIONS; k++)
                  if (got_w.feq[k] !== exp_w.feq[k])
                     report_mismatch($sformatf("feq_%0d got %0d expected %0d", k,
                        $signed(got_w.feq[k]), $signed(exp_w.feq[k])));
               if (got_w.last_cell !== exp_w.last_cell)
                  report_mismatch($sformatf("last_cell_out got %b expected %b",
                     got_w.last_cell, exp_w.last_cell));
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_DIR_X) dir_x_model = csr_wdata;
            else if (csr_index == CSR_DIR_Y) dir_y_model = csr_wdata;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset !== 1'b0) begin
         idle_cycles = 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : response_sink
      int  gap;
      int  words_taken;
      bit  burst;
      words_taken = 0;
      burst       = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 5);
         // long hold so the pipe fills and backs up into the request side
         if (words_taken == 300 || words_taken == 1200) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         words_taken++;
      end
   end

   initial begin : stimulus
      mismatch_count = 0;
      offer_burst    = 1'b0;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= CSR_DIR_X;
      csr_wdata        <= '0;
      req_if.valid     <= 1'b0;
      req_if.density   <= '0;
      req_if.vel_x     <= '0;
      req_if.vel_y     <= '0;
      req_if.last_cell <= 1'b0;
      offer_has_typed  <= 1'b0;
      offer_typed_word <= '0;

      directed_rows.push_back(typed_row(16'd0, 16'sd0, 16'sd0, 1'b0, 0, 0, 0));
      directed_rows.push_back(typed_row(16'd16384, 16'sd0, 16'sd0, 1'b0, 7282, 1820, 455));
      directed_rows.push_back(typed_row(16'd65535, 16'sd0, 16'sd0, 1'b1, 29127, 7282, 1820));
      directed_rows.push_back(typed_row(16'd0, 16'sh8000, 16'sh7FFF, 1'b1, 0, 0, 0));
      // saturation both ways
      directed_rows.push_back(cell_row(16'd65535, 16'sh7FFF, 16'sh7FFF, 1'b0));
      directed_rows.push_back(cell_row(16'd65535, 16'sh8000, 16'sh8000, 1'b0));
      directed_rows.push_back(cell_row(16'd16384, 16'sd8192, 16'sd0, 1'b0));
      directed_rows.push_back(cell_row(16'd16384, 16'sd0, -16'sd8192, 1'b0));
      directed_rows.push_back(cell_row(16'd40000, 16'sd16384, -16'sd16384, 1'b1));
      // writes to indexes with no register are dropped
      directed_rows.push_back(csr_row(CSR_SPARE_2, DIR_ALL_ZERO));
      directed_rows.push_back(csr_row(CSR_SPARE_3, DIR_ALL_MINUS));
      directed_rows.push_back(cell_row(16'd16384, 16'sd4096, 16'sd4096, 1'b0));
      // component code binary 10 stands for minus two
      directed_rows.push_back(csr_row(CSR_DIR_X, DIR_ALL_MINUS2));
      directed_rows.push_back(csr_row(CSR_DIR_Y, DIR_ALL_MINUS2));
      directed_rows.push_back(cell_row(16'd65535, 16'sh7FFF, 16'sh8000, 1'b0));
      directed_rows.push_back(cell_row(16'd20000, 16'sd5000, 16'sd3000, 1'b0));
      directed_rows.push_back(csr_row(CSR_DIR_X, DIR_ALL_ZERO));
      directed_rows.push_back(csr_row(CSR_DIR_Y, DIR_ALL_MINUS));
      directed_rows.push_back(cell_row(16'd65535, 16'sh7FFF, 16'sh7FFF, 1'b1));
      directed_rows.push_back(cell_row(16'd30000, -16'sd12000, 16'sd700, 1'b0));
      directed_rows.push_back(csr_row(CSR_DIR_X, DIR_X_RESET));
      directed_rows.push_back(csr_row(CSR_DIR_Y, DIR_Y_RESET));
      directed_rows.push_back(cell_row(16'd65535, 16'sd1, -16'sd1, 1'b0));

      phase_x[0] = DIR_X_RESET;            phase_y[0] = DIR_Y_RESET;
      phase_x[1] = CSR_W'($urandom);       phase_y[1] = CSR_W'($urandom);
      phase_x[2] = DIR_ALL_MINUS;          phase_y[2] = DIR_ALL_MINUS;
      phase_x[3] = DIR_ALL_MINUS2;         phase_y[3] = DIR_ALL_PLUS;
      phase_x[4] = DIR_ALL_ZERO;           phase_y[4] = CSR_W'($urandom);
      phase_x[5] = CSR_W'($urandom);       phase_y[5] = CSR_W'($urandom);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_pipeline();
            write_csr(directed_rows[i].csr_index, directed_rows[i].csr_data);
         end else begin
            send_cell(directed_rows[i], next_offer_gap());
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_pipeline();
         write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, CSR_W'($urandom));
         write_csr(CSR_DIR_X, phase_x[ph]);
         write_csr(CSR_DIR_Y, phase_y[ph]);
         repeat (CELLS_PER_PHASE) send_cell(random_cell(), next_offer_gap());
      end

      drain_pipeline();
      repeat (2 * NUM_STAGES) @(posedge clock);
      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
